/* sv/lzte_pkg.sv */
package lzte_pkg;

    localparam int DICT_SIZE_DEF = 128;
    localparam int LOOK_SIZE_DEF = 16;
    localparam int POS_W = 7;
    localparam int LEN_W = 4;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_FILL = 6'b000010,
        ST_RD   = 6'b000100,
        ST_CMP  = 6'b001000,
        ST_EMIT = 6'b010000,
        ST_SLIDE = 6'b100000
    } state_t;

    typedef struct packed {
        logic accept;
        logic fill;
        logic rd_issue;
        logic adv_i;
        logic pos_end;
        logic emit;
        logic slide;
    } cmd_t;

    typedef struct packed {
        logic first_seen;
        logic acc_search;
        logic fill_last;
        logic i_at_limit;
        logic last_p;
        logic data_eq;
        logic out_free;
        logic slide_last;
        logic more_flush;
    } stat_t;

endpackage

/* sv/lzte_ctrl.sv */
module lzte_ctrl
    import lzte_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    input  logic   s_end_of_stream,
    output logic   s_ready,
    input  stat_t  stat,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE) && (stat.first_seen || stat.out_free);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.accept = 1'b1;
                    if (!stat.first_seen) begin
                        state_next = s_end_of_stream ? ST_IDLE : ST_FILL;
                    end else if (stat.acc_search) begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_FILL: begin
                cmd.fill = 1'b1;
                if (stat.fill_last) state_next = ST_IDLE;
            end
            ST_RD: begin
                if (stat.i_at_limit) begin
                    cmd.pos_end = 1'b1;
                    if (stat.last_p) state_next = ST_EMIT;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (stat.data_eq) begin
                    cmd.adv_i = 1'b1;
                    state_next = ST_RD;
                end else begin
                    cmd.pos_end = 1'b1;
                    state_next = stat.last_p ? ST_EMIT : ST_RD;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    state_next = ST_SLIDE;
                end
            end
            ST_SLIDE: begin
                cmd.slide = 1'b1;
                if (stat.slide_last) state_next = stat.more_flush ? ST_RD : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

endmodule

/* sv/lzte_dp.sv */
module lzte_dp
    import lzte_pkg::*;
#(
    parameter int DICT_SIZE = DICT_SIZE_DEF,
    parameter int LOOK_SIZE = LOOK_SIZE_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [7:0]       s_data_byte,
    input  logic             s_end_of_stream,
    input  cmd_t             cmd,
    output stat_t            stat,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [POS_W-1:0] m_match_position,
    output logic [LEN_W-1:0] m_match_length,
    output logic [7:0]       m_next_symbol,
    output logic             m_last_of_run,
    output logic             m_stream_done
);

    localparam int DW = $clog2(DICT_SIZE);
    localparam int LW = (LOOK_SIZE > 1) ? $clog2(LOOK_SIZE) : 1;
    localparam int CW = $clog2(LOOK_SIZE + 1);
    localparam int XW = DW + CW + 1;

    logic [7:0] win_mem [DICT_SIZE];
    logic [7:0] win_rdata_reg;
    logic [7:0] look_reg [LOOK_SIZE];

    logic [DW-1:0] wbase_reg, p_reg, fill_reg, bpos_reg;
    logic [CW-1:0] i_reg, best_reg, maxlen_reg, k_reg, count_reg;
    logic [LW-1:0] lhead_reg;
    logic          first_reg, flush_reg;
    logic [7:0]    byte_reg;

    logic             m_valid_reg;
    logic [POS_W-1:0] pos_reg;
    logic [LEN_W-1:0] len_reg;
    logic [7:0]       sym_reg;
    logic             last_reg, done_reg;

    function automatic logic [DW-1:0] widx(logic [DW-1:0] base, logic [DW:0] off);
        logic [DW+1:0] s;
        s = {2'b0, base} + {1'b0, off};
        if (s >= (DW+2)'(DICT_SIZE)) s = s - (DW+2)'(DICT_SIZE);
        return s[DW-1:0];
    endfunction

    function automatic logic [LW-1:0] lidx(logic [LW-1:0] base, logic [CW-1:0] off);
        logic [CW+LW:0] s;
        s = (CW+LW+1)'(base) + (CW+LW+1)'(off);
        if (s >= (CW+LW+1)'(LOOK_SIZE)) s = s - (CW+LW+1)'(LOOK_SIZE);
        return s[LW-1:0];
    endfunction

    logic [CW-1:0] look_off;
    logic [7:0]    look_rd;
    logic [DW:0]   rem;
    logic [CW:0]   n_ext;
    logic [CW-1:0] count_after;
    logic          win_we;
    logic [DW-1:0] win_waddr, win_raddr;
    logic [7:0]    win_wdata;

    always_comb begin
        if (cmd.emit) look_off = best_reg;
        else if (cmd.slide) look_off = k_reg;
        else look_off = i_reg;
    end
    assign look_rd = look_reg[lidx(lhead_reg, look_off)];

    assign rem = (DW+1)'(DICT_SIZE) - {1'b0, p_reg};
    assign n_ext = {1'b0, best_reg} + (CW+1)'(1);
    assign count_after = count_reg - n_ext[CW-1:0];

    assign stat.first_seen = first_reg;
    assign stat.acc_search = s_end_of_stream || (count_reg == CW'(LOOK_SIZE - 1));
    assign stat.fill_last  = (fill_reg == DW'(DICT_SIZE - 1));
    assign stat.i_at_limit = (XW'(i_reg) == XW'(maxlen_reg)) || (XW'(i_reg) == XW'(rem));
    assign stat.last_p     = (p_reg == DW'(DICT_SIZE - 1));
    assign stat.data_eq    = (win_rdata_reg == look_rd);
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign stat.slide_last = (k_reg == best_reg);
    assign stat.more_flush = flush_reg && (count_after != '0);

    assign win_raddr = widx(wbase_reg, (DW+1)'(p_reg) + (DW+1)'(i_reg));
    assign win_we    = cmd.fill || cmd.slide;
    assign win_waddr = cmd.fill ? fill_reg : widx(wbase_reg, (DW+1)'(k_reg));
    assign win_wdata = cmd.fill ? byte_reg : look_rd;

    always_ff @(posedge aclk) begin
        if (win_we) win_mem[win_waddr] <= win_wdata;
        if (cmd.rd_issue) win_rdata_reg <= win_mem[win_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && first_reg) look_reg[lidx(lhead_reg, count_reg)] <= s_data_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg   <= 1'b0;
            flush_reg   <= 1'b0;
            count_reg   <= '0;
            lhead_reg   <= '0;
            wbase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) m_valid_reg <= 1'b0;
            if (cmd.accept) begin
                if (!first_reg) begin
                    m_valid_reg <= 1'b1;
                    pos_reg  <= '0;
                    len_reg  <= '0;
                    sym_reg  <= s_data_byte;
                    last_reg <= 1'b1;
                    done_reg <= s_end_of_stream;
                    first_reg <= !s_end_of_stream;
                    fill_reg <= '0;
                    byte_reg <= s_data_byte;
                    wbase_reg <= '0;
                end else begin
                    count_reg <= count_reg + CW'(1);
                    if (stat.acc_search) begin
                        flush_reg  <= s_end_of_stream;
                        maxlen_reg <= count_reg;
                        p_reg    <= '0;
                        i_reg    <= '0;
                        best_reg <= '0;
                        bpos_reg <= '0;
                    end
                end
            end
            if (cmd.fill) fill_reg <= fill_reg + DW'(1);
            if (cmd.adv_i) i_reg <= i_reg + CW'(1);
            if (cmd.pos_end) begin
                if (i_reg > best_reg) begin
                    best_reg <= i_reg;
                    bpos_reg <= p_reg;
                end
                p_reg <= p_reg + DW'(1);
                i_reg <= '0;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
                pos_reg  <= POS_W'(bpos_reg);
                len_reg  <= LEN_W'(best_reg);
                sym_reg  <= look_rd;
                last_reg <= !flush_reg || (count_after == '0);
                done_reg <= flush_reg && (count_after == '0);
                k_reg    <= '0;
            end
            if (cmd.slide) begin
                k_reg <= k_reg + CW'(1);
                if (stat.slide_last) begin
                    wbase_reg <= widx(wbase_reg, (DW+1)'(n_ext));
                    lhead_reg <= lidx(lhead_reg, n_ext[CW-1:0]);
                    count_reg <= count_after;
                    if (stat.more_flush) begin
                        maxlen_reg <= count_after - CW'(1);
                        p_reg    <= '0;
                        i_reg    <= '0;
                        best_reg <= '0;
                        bpos_reg <= '0;
                    end else if (flush_reg) begin
                        first_reg <= 1'b0;
                        flush_reg <= 1'b0;
                        count_reg <= '0;
                        lhead_reg <= '0;
                    end
                end
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_match_position = pos_reg;
    assign m_match_length   = len_reg;
    assign m_next_symbol    = sym_reg;
    assign m_last_of_run    = last_reg;
    assign m_stream_done    = done_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(LOOK_SIZE)) else $error("lookahead count overflow");
    a_i_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.adv_i |-> i_reg < maxlen_reg) else $error("match index past limit");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> best_reg <= maxlen_reg) else $error("match longer than limit");
`endif

endmodule

/* sv/lz77_triple_encoder.sv */
// Operation: the first byte of a stream gives its literal in the cycle after transfer,
// then, unless it ends the stream, fills the window with that byte. Each triple comes
// from a search over every window position, an emit that waits while m_ready holds
// the output, and a slide of the window by L+1 bytes (L = match length).
// Throughput: one byte transfer per cycle while the lookahead fills.
// Reset: synchronous active-low aresetn clears control; window is written before use.
module lz77_triple_encoder
    import lzte_pkg::*;
#(
    parameter int DICT_SIZE = DICT_SIZE_DEF,
    parameter int LOOK_SIZE = LOOK_SIZE_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_end_of_stream,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [POS_W-1:0] m_match_position,
    output logic [LEN_W-1:0] m_match_length,
    output logic [7:0]       m_next_symbol,
    output logic             m_last_of_run,
    output logic             m_stream_done
);

    cmd_t  cmd;
    stat_t stat;

    lzte_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_end_of_stream (s_end_of_stream),
        .s_ready         (s_ready),
        .stat            (stat),
        .cmd             (cmd)
    );

    lzte_dp #(
        .DICT_SIZE (DICT_SIZE),
        .LOOK_SIZE (LOOK_SIZE)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_data_byte      (s_data_byte),
        .s_end_of_stream  (s_end_of_stream),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match_position (m_match_position),
        .m_match_length   (m_match_length),
        .m_next_symbol    (m_next_symbol),
        .m_last_of_run    (m_last_of_run),
        .m_stream_done    (m_stream_done)
    );

endmodule

/* test/tb_lz77_triple_encoder.sv */
module tb_lz77_triple_encoder
    import lzte_pkg::*;
;

    localparam int WIN = DICT_SIZE_DEF;
    localparam int LOOK = LOOK_SIZE_DEF;

    typedef struct {
        logic [7:0] data_byte;
        logic       eos;
        logic       hold;
    } byte_item_t;

    typedef struct {
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic [7:0]       sym;
        logic             last;
        logic             done;
    } triple_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_data_byte = '0;
    logic             s_end_of_stream = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [POS_W-1:0] m_match_position;
    logic [LEN_W-1:0] m_match_length;
    logic [7:0]       m_next_symbol;
    logic             m_last_of_run;
    logic             m_stream_done;

    lz77_triple_encoder dut (.*);

    always #5 aclk = ~aclk;

    byte_item_t pending_bytes[$];
    triple_t    expected_triples[$];
    int         mismatches = 0;

    // encoder mirror
    logic [7:0] window_mem[WIN];
    logic [7:0] look_mem[LOOK];
    int         look_cnt = 0;
    bit         stream_open = 0;

    function automatic void reset_encoder();
        look_cnt = 0;
        stream_open = 0;
    endfunction

    function automatic triple_t encode_head(int maxlen);
        triple_t t;
        int      len, p, n, best_len, best_pos;
        bit      hit, found;
        best_len = 0;
        best_pos = 0;
        found = 0;
        for (len = maxlen; len > 0 && !found; len--) begin
            for (p = 0; p + len <= WIN && !found; p++) begin
                hit = 1;
                for (int k = 0; k < len; k++)
                    if (window_mem[p + k] != look_mem[k]) hit = 0;
                if (hit) begin
                    found = 1;
                    best_len = len;
                    best_pos = p;
                end
            end
        end
        t.pos = best_pos[POS_W-1:0];
        t.len = best_len[LEN_W-1:0];
        t.sym = look_mem[best_len];
        t.last = 0;
        t.done = 0;
        n = best_len + 1;
        for (int k = 0; k < WIN - n; k++) window_mem[k] = window_mem[k + n];
        for (int k = 0; k < n; k++) window_mem[WIN - n + k] = look_mem[k];
        for (int k = 0; k < LOOK - n; k++) look_mem[k] = look_mem[k + n];
        look_cnt -= n;
        return t;
    endfunction

    function automatic void encode_byte(logic [7:0] b, logic eos);
        triple_t t;
        if (!stream_open) begin
            for (int k = 0; k < WIN; k++) window_mem[k] = b;
            t = '{pos: '0, len: '0, sym: b, last: 1'b1, done: eos};
            expected_triples.push_back(t);
            if (eos) reset_encoder();
            else stream_open = 1;
            return;
        end
        if (look_cnt < LOOK) begin
            look_mem[look_cnt] = b;
            look_cnt++;
        end
        if (eos) begin
            while (look_cnt > 0) begin
                t = encode_head(look_cnt - 1);
                if (look_cnt == 0) begin
                    t.last = 1;
                    t.done = 1;
                end
                expected_triples.push_back(t);
            end
            reset_encoder();
        end else if (look_cnt >= LOOK) begin
            t = encode_head(LOOK - 1);
            t.last = 1;
            expected_triples.push_back(t);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // source side
    int src_gap = 0;
    always @(posedge aclk) begin
        byte_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) encode_byte(s_data_byte, s_end_of_stream);
            if (!(s_valid && !s_ready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() > 0 &&
                             !(pending_bytes[0].hold && expected_triples.size() > 0)) begin
                    it = pending_bytes.pop_front();
                    s_valid <= 1'b1;
                    s_data_byte <= it.data_byte;
                    s_end_of_stream <= it.eos;
                    src_gap = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // sink side
    int sink_gap = 0;
    always @(posedge aclk) begin
        triple_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_triples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: pos %0d len %0d sym %0d",
                                 m_match_position, m_match_length, m_next_symbol);
                end else begin
                    e = expected_triples.pop_front();
                    if (e.pos !== m_match_position || e.len !== m_match_length ||
                        e.sym !== m_next_symbol || e.last !== m_last_of_run ||
                        e.done !== m_stream_done) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"triple mismatch: exp pos %0d len %0d sym %0d last %0b ",
                                      "done %0b, got pos %0d len %0d sym %0d last %0b done %0b"},
                                     e.pos, e.len, e.sym, e.last, e.done,
                                     m_match_position, m_match_length, m_next_symbol,
                                     m_last_of_run, m_stream_done);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                sink_gap = pick_gap();
            end
        end
    end

    function automatic void add_stream(int n, int alphabet, bit hold_first);
        byte_item_t it;
        for (int k = 0; k < n; k++) begin
            if (alphabet >= 256) it.data_byte = 8'($urandom_range(0, 255));
            else it.data_byte = 8'h41 + 8'($urandom_range(0, alphabet - 1));
            it.eos = (k == n - 1);
            it.hold = hold_first && k == 0;
            pending_bytes.push_back(it);
        end
    endfunction

    function automatic void add_const(logic [7:0] b, int n);
        for (int k = 0; k < n; k++)
            pending_bytes.push_back('{data_byte: b, eos: k == n - 1, hold: 1'b0});
    endfunction

    initial begin
        int total, n, alpha;
        // single-byte stream, both extremes
        add_const(8'h00, 1);
        add_const(8'hff, 1);
        // runs of one byte: full-length matches once the buffer fills
        add_const(8'h00, 19);
        pending_bytes.push_back('{data_byte: 8'h5a, eos: 1'b0, hold: 1'b0});
        pending_bytes.push_back('{data_byte: 8'ha5, eos: 1'b1, hold: 1'b0});
        total = pending_bytes.size();
        for (int s = 0; total < 470; s++) begin
            case ($urandom_range(0, 9))
                0: n = $urandom_range(1, 4);
                1: n = $urandom_range(40, 90);
                default: n = $urandom_range(5, 35);
            endcase
            if (n > 470 - total) n = 470 - total;
            case ($urandom_range(0, 3))
                0: alpha = 256;
                1: alpha = 2;
                default: alpha = $urandom_range(2, 6);
            endcase
            add_stream(n, alpha, s == 3);
            total += n;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (pending_bytes.size() > 0 || s_valid || expected_triples.size() > 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && expected_triples.size() == 0) begin
            $display("lz77_triple_encoder regression: pass");
        end else begin
            $display("lz77_triple_encoder regression: fail");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("lz77_triple_encoder regression: fail");
        $finish;
    end

endmodule
